@@ src/fbrgb_pkg.sv @@
// Shared types and constants for the framebuffer to RGB888 converter.
package fbrgb_pkg;

	localparam int PIX_W       = 32;
	localparam int QUEUE_DEPTH = 4;
	localparam int SCALE_SHIFT = 24;

	// Configuration register indexes
	localparam logic [2:0] REG_BYTES_PER_PIXEL = 3'd0;
	localparam logic [2:0] REG_IMAGE_WIDTH     = 3'd1;
	localparam logic [2:0] REG_RED_OFFSET      = 3'd2;
	localparam logic [2:0] REG_RED_LENGTH      = 3'd3;
	localparam logic [2:0] REG_GREEN_OFFSET    = 3'd4;
	localparam logic [2:0] REG_GREEN_LENGTH    = 3'd5;
	localparam logic [2:0] REG_BLUE_OFFSET     = 3'd6;
	localparam logic [2:0] REG_BLUE_LENGTH     = 3'd7;

	// floor(n/d) == (n * ceil(2^24/d)) >> 24 for n <= 255*127; n = v*255 folded in
	localparam logic [31:0] SCALE_MUL_1 = 32'(64'd255 * ((64'd1 << SCALE_SHIFT) / 64'd1));
	localparam logic [31:0] SCALE_MUL_2 = 32'(64'd255 * (((64'd1 << SCALE_SHIFT) + 64'd2) / 64'd3));
	localparam logic [31:0] SCALE_MUL_3 = 32'(64'd255 * (((64'd1 << SCALE_SHIFT) + 64'd6) / 64'd7));
	localparam logic [31:0] SCALE_MUL_4 = 32'(64'd255 * (((64'd1 << SCALE_SHIFT) + 64'd14) / 64'd15));
	localparam logic [31:0] SCALE_MUL_5 = 32'(64'd255 * (((64'd1 << SCALE_SHIFT) + 64'd30) / 64'd31));
	localparam logic [31:0] SCALE_MUL_6 = 32'(64'd255 * (((64'd1 << SCALE_SHIFT) + 64'd62) / 64'd63));
	localparam logic [31:0] SCALE_MUL_7 =
		32'(64'd255 * (((64'd1 << SCALE_SHIFT) + 64'd126) / 64'd127));

	typedef struct packed {
		logic [4:0] offset;
		logic [4:0] length;
	} chan_cfg_t;

	typedef struct packed {
		chan_cfg_t red;
		chan_cfg_t green;
		chan_cfg_t blue;
	} rgb_cfg_t;

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic             last;
	} pix_word_t;

endpackage

@@ src/fbrgb_front.sv @@
// Byte gatherer: assembles pixels, tracks the column and drops padding.
module fbrgb_front import fbrgb_pkg::*; #(
	parameter int WIDTH_LIMIT = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic [7:0]  data_byte,
	input  logic        row_end,
	input  logic [2:0]  bytes_per_pixel,
	input  logic [12:0] image_width,
	input  logic        q_full,
	output logic        q_push,
	output pix_word_t   q_word
);

	localparam int COL_W = $clog2(WIDTH_LIMIT + 1);

	logic [1:0]       byte_index_q;
	logic [23:0]      pixel_bytes_q;
	logic [COL_W-1:0] pixel_column_q;

	logic             accept;
	logic [2:0]       bpp;
	logic [COL_W-1:0] width;
	logic [COL_W-1:0] col_next;
	logic             active;
	logic             complete;
	logic [PIX_W-1:0] shifted;

	assign accept = push && !q_full;

	always_comb begin
		if (bytes_per_pixel inside {[3'd2:3'd4]}) begin
			bpp = bytes_per_pixel;
		end else begin
			bpp = 3'd4;
		end
		if (int'(image_width) > WIDTH_LIMIT) begin
			width = COL_W'(WIDTH_LIMIT);
		end else begin
			width = COL_W'(image_width);
		end
	end

	assign col_next = pixel_column_q + COL_W'(1);
	assign active   = pixel_column_q < width;
	assign complete = active && (({1'b0, byte_index_q} + 3'd1) >= bpp);
	assign shifted  = PIX_W'(data_byte) << {byte_index_q, 3'b000};

	assign q_push      = accept && complete;
	assign q_word.pix  = PIX_W'(pixel_bytes_q) | shifted;
	assign q_word.last = col_next == width;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_index_q   <= '0;
			pixel_bytes_q  <= '0;
			pixel_column_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				// restart the row; a partial pixel is dropped
				byte_index_q   <= '0;
				pixel_bytes_q  <= '0;
				pixel_column_q <= '0;
			end else if (complete) begin
				byte_index_q   <= '0;
				pixel_bytes_q  <= '0;
				pixel_column_q <= col_next;
			end else if (active) begin
				byte_index_q  <= byte_index_q + 2'd1;
				pixel_bytes_q <= pixel_bytes_q | shifted[23:0];
			end
		end
	end

endmodule

@@ src/fbrgb_queue.sv @@
// Short queue of assembled pixel words between the gatherer and the converter.
module fbrgb_queue import fbrgb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  pix_word_t word_in,
	output logic      full,
	output logic      valid,
	output pix_word_t word_out,
	input  logic      pop
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	pix_word_t        mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = count_q == (PTR_W+1)'(QUEUE_DEPTH);
	assign valid    = count_q != '0;
	assign word_out = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= word_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (PTR_W+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (PTR_W+1)'(1);
			end
		end
	end

endmodule

@@ src/fbrgb_back.sv @@
// Channel converter: field extraction, then scaling into the output register.
module fbrgb_back import fbrgb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  rgb_cfg_t  rgb_cfg,
	input  logic      q_valid,
	input  pix_word_t q_word,
	output logic      q_pop,
	output logic      empty,
	input  logic      pop,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic      last_in_row
);

	typedef struct packed {
		logic       is_long;
		logic [7:0] long_val;
		logic [2:0] len;
		logic [6:0] v;
	} chan_s1_t;

	function automatic chan_s1_t extract(logic [PIX_W-1:0] pix, chan_cfg_t c);
		chan_s1_t         r;
		logic [5:0]       sh;
		logic [2*PIX_W-1:0] wide;
		logic [PIX_W-1:0] low;
		r    = '0;
		wide = {{PIX_W{1'b0}}, pix};
		sh   = {1'b0, c.offset} + {1'b0, c.length} - 6'd8;
		low  = pix >> c.offset;
		if (c.length >= 5'd8) begin
			// take the top eight bits of the field
			r.is_long  = 1'b1;
			r.long_val = 8'(wide >> sh);
		end else begin
			r.len = c.length[2:0];
			r.v   = low[6:0] & 7'((8'h1 << c.length[2:0]) - 8'h1);
		end
		return r;
	endfunction

	function automatic logic [31:0] scale_mul(logic [2:0] len);
		logic [31:0] m;
		case (len)
			3'd1:    m = SCALE_MUL_1;
			3'd2:    m = SCALE_MUL_2;
			3'd3:    m = SCALE_MUL_3;
			3'd4:    m = SCALE_MUL_4;
			3'd5:    m = SCALE_MUL_5;
			3'd6:    m = SCALE_MUL_6;
			3'd7:    m = SCALE_MUL_7;
			default: m = '0;
		endcase
		return m;
	endfunction

	function automatic logic [7:0] scale(chan_s1_t c);
		logic [38:0] prod;
		prod = {32'b0, c.v} * {7'b0, scale_mul(c.len)};
		if (c.is_long) begin
			return c.long_val;
		end
		return prod[SCALE_SHIFT +: 8];
	endfunction

	logic     valid_s1;
	chan_s1_t red_s1;
	chan_s1_t green_s1;
	chan_s1_t blue_s1;
	logic     last_s1;
	logic     valid_s2;
	logic     adv_s1;

	assign adv_s1 = valid_s1 && (!valid_s2 || pop);
	assign q_pop  = q_valid && (!valid_s1 || adv_s1);
	assign empty  = !valid_s2;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			red_s1   <= extract(q_word.pix, rgb_cfg.red);
			green_s1 <= extract(q_word.pix, rgb_cfg.green);
			blue_s1  <= extract(q_word.pix, rgb_cfg.blue);
			last_s1  <= q_word.last;
		end
		if (adv_s1) begin
			red         <= scale(red_s1);
			green       <= scale(green_s1);
			blue        <= scale(blue_s1);
			last_in_row <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (q_pop) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (pop) begin
				valid_s2 <= 1'b0;
			end
		end
	end

endmodule

@@ src/framebuffer_bitfield_to_rgb888.sv @@
// Top level: configuration registers, byte gatherer, pixel queue, converter.
// Throughput: one byte per cycle while full is low; one RGB888 word per
// bytes_per_pixel bytes, via the queue, extraction stage and result register.
// The four-entry pixel queue and two-stage converter let either side stall.
// Reset (arst_n low) clears row state, queue and stages; registers take
// their default 32-bit xRGB layout at 640 pixels per row.
module framebuffer_bitfield_to_rgb888 import fbrgb_pkg::*; #(
	parameter int WIDTH_LIMIT = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        row_end,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic        last_in_row,
	input  logic        cfg_wr,
	input  logic [2:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	logic [2:0]  bytes_per_pixel_q;
	logic [12:0] image_width_q;
	rgb_cfg_t    rgb_cfg_q;

	logic        q_push;
	pix_word_t   q_word_in;
	logic        q_valid;
	pix_word_t   q_word_out;
	logic        q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_per_pixel_q      <= 3'd4;
			image_width_q          <= 13'd640;
			rgb_cfg_q.red.offset   <= 5'd16;
			rgb_cfg_q.red.length   <= 5'd8;
			rgb_cfg_q.green.offset <= 5'd8;
			rgb_cfg_q.green.length <= 5'd8;
			rgb_cfg_q.blue.offset  <= 5'd0;
			rgb_cfg_q.blue.length  <= 5'd8;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_BYTES_PER_PIXEL: bytes_per_pixel_q      <= cfg_data[2:0];
				REG_IMAGE_WIDTH:     image_width_q          <= cfg_data;
				REG_RED_OFFSET:      rgb_cfg_q.red.offset   <= cfg_data[4:0];
				REG_RED_LENGTH:      rgb_cfg_q.red.length   <= cfg_data[4:0];
				REG_GREEN_OFFSET:    rgb_cfg_q.green.offset <= cfg_data[4:0];
				REG_GREEN_LENGTH:    rgb_cfg_q.green.length <= cfg_data[4:0];
				REG_BLUE_OFFSET:     rgb_cfg_q.blue.offset  <= cfg_data[4:0];
				REG_BLUE_LENGTH:     rgb_cfg_q.blue.length  <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	fbrgb_front #(
		.WIDTH_LIMIT(WIDTH_LIMIT)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.data_byte       (data_byte),
		.row_end         (row_end),
		.bytes_per_pixel (bytes_per_pixel_q),
		.image_width     (image_width_q),
		.q_full          (full),
		.q_push          (q_push),
		.q_word          (q_word_in)
	);

	fbrgb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.word_in  (q_word_in),
		.full     (full),
		.valid    (q_valid),
		.word_out (q_word_out),
		.pop      (q_pop)
	);

	fbrgb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.rgb_cfg     (rgb_cfg_q),
		.q_valid     (q_valid),
		.q_word      (q_word_out),
		.q_pop       (q_pop),
		.empty       (empty),
		.pop         (pop),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.last_in_row (last_in_row)
	);

endmodule

@@ src/fbrgb_checker.sv @@
// Port-level checks for the converter, bound to the top level.
module fbrgb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic [7:0]  red,
	input logic [7:0]  green,
	input logic [7:0]  blue,
	input logic        last_in_row
);

	// reset leaves nothing to deliver and room to accept
	a_reset_clear: assert property (@(posedge clk) !arst_n |=> (empty && !full))
		else $error("result or full seen after a reset edge");

	// the pixel queue only backs up while the output word is stalled
	a_full_has_word: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("full while no word waits at the output");

	a_word_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("waiting word withdrawn");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> $stable({red, green, blue, last_in_row}))
		else $error("waiting word changed");

endmodule

bind framebuffer_bitfield_to_rgb888 fbrgb_checker u_fbrgb_checker (.*);
